### hdl/bone_world_position_transform_top_defines.svh
// Assertion macros shared by the transform block.
`ifndef BONE_WORLD_POSITION_TRANSFORM_TOP_DEFINES_SVH
`define BONE_WORLD_POSITION_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BWPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BWPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bwpt_pkg.sv
// Types, constants and step tables of the bone world position transform.
package bwpt_pkg;

  localparam int W_Q     = 32;
  localparam int W_T     = 48;
  localparam int W_MUL   = 48;
  localparam int W_PROD  = 2 * W_MUL;
  localparam int W_CNT   = 6;
  localparam int W_QP    = 35;
  localparam int W_ROT   = 37;
  localparam int W_ACC   = 98;
  localparam int W_STEP  = 5;
  localparam int Q_SHIFT = 29;
  localparam int M_SHIFT = 30;
  localparam int P_SHIFT = 16;
  localparam logic [W_STEP-1:0] LOAD_PROD_LAST = 5'd8;
  localparam logic [W_STEP-1:0] LOAD_LAST      = 5'd17;
  localparam logic [W_STEP-1:0] POINT_LAST     = 5'd8;
  localparam logic [W_ROT-1:0]  ONE_Q30        = 37'sd1 << 30;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } bwpt_state_t;

  typedef struct packed {
    logic                  cmd;
    logic signed [W_Q-1:0] quat_x;
    logic signed [W_Q-1:0] quat_y;
    logic signed [W_Q-1:0] quat_z;
    logic signed [W_Q-1:0] quat_w;
    logic signed [W_Q-1:0] scale_x;
    logic signed [W_Q-1:0] scale_y;
    logic signed [W_Q-1:0] scale_z;
    logic signed [W_T-1:0] trans_x;
    logic signed [W_T-1:0] trans_y;
    logic signed [W_T-1:0] trans_z;
  } bwpt_in_t;

  typedef struct packed {
    logic signed [W_T-1:0] pos_x;
    logic signed [W_T-1:0] pos_y;
    logic signed [W_T-1:0] pos_z;
  } bwpt_out_t;

  typedef struct packed {
    logic                      start;
    logic signed [W_MUL-1:0]   a;
    logic signed [W_MUL-1:0]   b;
  } bwpt_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [W_PROD-1:0]  prod;
  } bwpt_mul_rsp_t;

  // Point step s covers row i = s mod 3 of column j = s div 3.
  function automatic logic [1:0] pt_row(input logic [W_STEP-1:0] s);
    unique case (s)
      5'd0, 5'd3, 5'd6: pt_row = 2'd0;
      5'd1, 5'd4, 5'd7: pt_row = 2'd1;
      default:          pt_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pt_col(input logic [W_STEP-1:0] s);
    unique case (s)
      5'd0, 5'd1, 5'd2: pt_col = 2'd0;
      5'd3, 5'd4, 5'd5: pt_col = 2'd1;
      default:          pt_col = 2'd2;
    endcase
  endfunction

  // Matrix entry i*3+j used by point step s.
  function automatic logic [3:0] pt_entry(input logic [W_STEP-1:0] s);
    unique case (s)
      5'd0:    pt_entry = 4'd0;
      5'd1:    pt_entry = 4'd3;
      5'd2:    pt_entry = 4'd6;
      5'd3:    pt_entry = 4'd1;
      5'd4:    pt_entry = 4'd4;
      5'd5:    pt_entry = 4'd7;
      5'd6:    pt_entry = 4'd2;
      5'd7:    pt_entry = 4'd5;
      default: pt_entry = 4'd8;
    endcase
  endfunction

endpackage

### hdl/bwpt_mul.sv
// Bit-serial signed 48 by 48 multiplier, one multiplier bit per cycle.
module bwpt_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  bwpt_pkg::bwpt_mul_req_t req,
  output bwpt_pkg::bwpt_mul_rsp_t rsp
);
  import bwpt_pkg::*;

  logic signed [W_MUL-1:0] a_reg;
  logic        [W_MUL-1:0] b_sh;
  logic signed [W_MUL:0]   hi;
  logic        [W_MUL-1:0] lo;
  logic        [W_CNT-1:0] cnt;
  logic                    busy;
  logic                    done;
  logic                    last;
  logic signed [W_MUL+1:0] addend;
  logic signed [W_MUL+1:0] sum;

  assign last = (cnt == W_CNT'(W_MUL - 1));

  // The sign bit of the multiplier carries negative weight.
  always_comb begin
    if (!b_sh[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -{{2{a_reg[W_MUL-1]}}, a_reg};
    end else begin
      addend = {{2{a_reg[W_MUL-1]}}, a_reg};
    end
    sum = {hi[W_MUL], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_sh  <= req.b;
      hi    <= '0;
      lo    <= '0;
    end else if (busy) begin
      hi   <= sum[W_MUL+1:1];
      lo   <= {sum[0], lo[W_MUL-1:1]};
      b_sh <= {1'b0, b_sh[W_MUL-1:1]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi[W_MUL-1:0], lo};

endmodule

### hdl/bone_world_position_transform_top.sv
// Top level of the bone world position transform: sequencer, stored transform and output word.
// A point word gives its result after nine products on the multiplier.
// A load word takes eighteen products and gives no result.
// Each product runs on the single bit-serial 48 x 48 multiplier.
// Throughput: one word at a time; the next word is taken once the sequencer is idle.
// Reset (rst, synchronous, active high) clears the matrix, the offset and all control state.
module bone_world_position_transform_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwpt_pkg::bwpt_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bwpt_pkg::bwpt_out_t out_data
);
  import bwpt_pkg::*;

  `include "bone_world_position_transform_top_defines.svh"

  bwpt_state_t state, state_next;

  // The accepted word is held here while the sequencer works through its products.
  bwpt_in_t          in_reg;
  logic [W_STEP-1:0] step;

  // Stored transform: column-major rotation-scale matrix and the world offset.
  logic signed [W_T-1:0] matrix [9];
  logic signed [W_T-1:0] offset [3];

  // Quaternion products, already doubled and brought to Q.30.
  logic signed [W_QP-1:0] qprod [9];

  logic signed [W_ACC-1:0] acc;
  logic signed [W_T-1:0]   pos [3];

  bwpt_mul_req_t mul_req;
  bwpt_mul_rsp_t mul_rsp;

  logic                    is_last;
  logic [W_STEP-1:0]       k5;
  logic [3:0]              k;
  logic signed [W_ROT-1:0] rot;
  logic signed [W_Q-1:0]   scale_sel;
  logic signed [W_Q-1:0]   qa;
  logic signed [W_Q-1:0]   qb;
  logic signed [W_T-1:0]   t_sel;
  logic signed [W_ACC-1:0] acc_base;
  logic signed [W_ACC-1:0] acc_new;
  logic signed [W_ACC-P_SHIFT-1:0] shifted;
  logic signed [W_T-1:0]   sat_val;
  logic [1:0]              row;
  logic [1:0]              col;

  bwpt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign is_last = (in_reg.cmd == CMD_LOAD) ? (step == LOAD_LAST) : (step == POINT_LAST);
  assign k5      = step - 5'd9;
  assign k       = k5[3:0];
  assign row     = pt_row(step);
  assign col     = pt_col(step);

  // Quaternion product pairs for the first nine load steps.
  always_comb begin
    unique case (step)
      5'd0:    begin qa = in_reg.quat_x; qb = in_reg.quat_x; end
      5'd1:    begin qa = in_reg.quat_y; qb = in_reg.quat_y; end
      5'd2:    begin qa = in_reg.quat_z; qb = in_reg.quat_z; end
      5'd3:    begin qa = in_reg.quat_x; qb = in_reg.quat_y; end
      5'd4:    begin qa = in_reg.quat_x; qb = in_reg.quat_z; end
      5'd5:    begin qa = in_reg.quat_y; qb = in_reg.quat_z; end
      5'd6:    begin qa = in_reg.quat_w; qb = in_reg.quat_x; end
      5'd7:    begin qa = in_reg.quat_w; qb = in_reg.quat_y; end
      default: begin qa = in_reg.quat_w; qb = in_reg.quat_z; end
    endcase
  end

  // Rotation terms of the matrix, built from the stored products.
  // Order of products: xx, yy, zz, xy, xz, yz, wx, wy, wz.
  always_comb begin
    unique case (k)
      4'd0:    rot = ONE_Q30 - (W_ROT'(qprod[1]) + W_ROT'(qprod[2]));
      4'd1:    rot = W_ROT'(qprod[3]) + W_ROT'(qprod[8]);
      4'd2:    rot = W_ROT'(qprod[4]) - W_ROT'(qprod[7]);
      4'd3:    rot = W_ROT'(qprod[3]) - W_ROT'(qprod[8]);
      4'd4:    rot = ONE_Q30 - (W_ROT'(qprod[0]) + W_ROT'(qprod[2]));
      4'd5:    rot = W_ROT'(qprod[5]) + W_ROT'(qprod[6]);
      4'd6:    rot = W_ROT'(qprod[4]) + W_ROT'(qprod[7]);
      4'd7:    rot = W_ROT'(qprod[5]) - W_ROT'(qprod[6]);
      default: rot = ONE_Q30 - (W_ROT'(qprod[0]) + W_ROT'(qprod[1]));
    endcase
    unique case (k)
      4'd0, 4'd1, 4'd2: scale_sel = in_reg.scale_x;
      4'd3, 4'd4, 4'd5: scale_sel = in_reg.scale_y;
      default:          scale_sel = in_reg.scale_z;
    endcase
  end

  always_comb begin
    unique case (row)
      2'd0:    t_sel = in_reg.trans_x;
      2'd1:    t_sel = in_reg.trans_y;
      default: t_sel = in_reg.trans_z;
    endcase
  end

  // Multiplier operands for the current step.
  always_comb begin
    mul_req.start = (state == S_ISSUE);
    if (in_reg.cmd == CMD_POINT) begin
      mul_req.a = t_sel;
      mul_req.b = matrix[pt_entry(step)];
    end else if (step <= LOAD_PROD_LAST) begin
      mul_req.a = W_MUL'(qa);
      mul_req.b = W_MUL'(qb);
    end else begin
      mul_req.a = W_MUL'(rot);
      mul_req.b = W_MUL'(scale_sel);
    end
  end

  // Point accumulation: the first row of a column starts from the offset in Q.32.
  always_comb begin
    if (row == 2'd0) begin
      acc_base = W_ACC'(offset[col]) <<< P_SHIFT;
    end else begin
      acc_base = acc;
    end
    acc_new = acc_base + W_ACC'(mul_rsp.prod);
    shifted = acc_new[W_ACC-1:P_SHIFT];
    if (shifted[W_ACC-P_SHIFT-1:W_T-1] == '0 || shifted[W_ACC-P_SHIFT-1:W_T-1] == '1) begin
      sat_val = shifted[W_T-1:0];
    end else if (shifted[W_ACC-P_SHIFT-1]) begin
      sat_val = {1'b1, {(W_T-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(W_T-1){1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ISSUE;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (mul_rsp.done) begin
          if (!is_last) begin
            state_next = S_ISSUE;
          end else if (in_reg.cmd == CMD_POINT) begin
            state_next = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: if (!out_valid || out_ready) state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 9; i++) matrix[i] <= '0;
      for (int i = 0; i < 3; i++) offset[i] <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        step <= '0;
        if (in_data.cmd == CMD_LOAD) begin
          offset[0] <= in_data.trans_x;
          offset[1] <= in_data.trans_y;
          offset[2] <= in_data.trans_z;
        end
      end
      if (state == S_WAIT && mul_rsp.done) begin
        step <= step + 1'b1;
        if (in_reg.cmd == CMD_LOAD && step > LOAD_PROD_LAST) begin
          // The entry fits well inside 48 bits, so it is taken without saturation.
          matrix[k] <= mul_rsp.prod[M_SHIFT+W_T-1:M_SHIFT];
        end
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (state == S_WAIT && mul_rsp.done) begin
      if (in_reg.cmd == CMD_LOAD) begin
        if (step <= LOAD_PROD_LAST) begin
          qprod[step[3:0]] <= mul_rsp.prod[Q_SHIFT+W_QP-1:Q_SHIFT];
        end
      end else begin
        acc <= acc_new;
        if (row == 2'd2) begin
          pos[col] <= sat_val;
        end
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.pos_x <= pos[0];
      out_data.pos_y <= pos[1];
      out_data.pos_z <= pos[2];
    end
  end

  // The multiplier only finishes while the sequencer is waiting on it.
  `BWPT_ASSERT_IMP(a_done_in_wait, mul_rsp.done, state == S_WAIT, "product outside wait state")
  // Only a point word reaches the result stage.
  `BWPT_ASSERT_IMP(a_done_is_point, state == S_DONE, in_reg.cmd == CMD_POINT, "load gave a result")
  // The step counter never runs past the last product of the word.
  `BWPT_ASSERT_IMP(a_step_bound, state == S_WAIT,
                   (in_reg.cmd == CMD_LOAD) ? (step <= LOAD_LAST) : (step <= POINT_LAST),
                   "step beyond last product")
  // A product request is always followed by the wait state.
  `BWPT_ASSERT_NXT(a_issue_then_wait, state == S_ISSUE, state == S_WAIT, "issue not followed by wait")

endmodule
